// ===== src/sfcc_pkg.sv =====
package sfcc_pkg;

  localparam int STAGES     = 4;
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;

  localparam int STAGE_BITS = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int ENTRY_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_BITS   = $clog2(ENTRIES + 1);
  localparam int KEY_BITS   = 104;

  localparam logic [1:0] REG_STAGES  = 2'd0;
  localparam logic [1:0] REG_ENTRIES = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

  // One stage's view of a packet, from the table to the sequencer.
  typedef struct packed {
    logic                  hit;
    logic [COUNT_BITS-1:0] hit_count;
    logic [ENTRY_BITS-1:0] hit_idx;
    logic                  has_free;
    logic [ENTRY_BITS-1:0] free_idx;
    logic [OCC_BITS-1:0]   occupancy;
  } stage_view_t;

  // Write back from the sequencer to the table.
  typedef struct packed {
    logic                  we;
    logic                  is_new;
    logic [STAGE_BITS-1:0] stage;
    logic [ENTRY_BITS-1:0] idx;
    logic [COUNT_BITS-1:0] count;
  } wr_cmd_t;

endpackage

// ===== src/sfcc_table.sv =====
module sfcc_table (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  logic [sfcc_pkg::STAGE_BITS-1:0]      rd_stage,
  input  logic [sfcc_pkg::KEY_BITS-1:0]        key,
  output sfcc_pkg::stage_view_t                view,
  input  sfcc_pkg::wr_cmd_t                    wr
);

  localparam int SLOTS = sfcc_pkg::STAGES * sfcc_pkg::ENTRIES;
  localparam int ROW_BITS = sfcc_pkg::ENTRIES * (sfcc_pkg::KEY_BITS + sfcc_pkg::COUNT_BITS);

  // One memory row holds a whole stage: keys and counts for every entry.
  logic [ROW_BITS-1:0] row_mem [sfcc_pkg::STAGES];
  logic [ROW_BITS-1:0] row_q;
  logic [sfcc_pkg::ENTRIES-1:0] valid_r [sfcc_pkg::STAGES];
  logic [sfcc_pkg::OCC_BITS-1:0] occ_r [sfcc_pkg::STAGES];
  logic [sfcc_pkg::ENTRIES-1:0] vq_r;
  logic [sfcc_pkg::OCC_BITS-1:0] oq_r;
  logic [ROW_BITS-1:0] row_wr;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_q <= row_mem[rd_stage];
    end
    if (wr.we) begin
      row_mem[wr.stage] <= row_wr;
    end
  end

  // Merge the new entry into the row read last for this packet.
  always_comb begin
    row_wr = row_q;
    row_wr[wr.idx * (sfcc_pkg::KEY_BITS + sfcc_pkg::COUNT_BITS) +: sfcc_pkg::COUNT_BITS]
      = wr.count;
    if (wr.is_new) begin
      row_wr[wr.idx * (sfcc_pkg::KEY_BITS + sfcc_pkg::COUNT_BITS) + sfcc_pkg::COUNT_BITS
             +: sfcc_pkg::KEY_BITS] = key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < sfcc_pkg::STAGES; s++) begin
        valid_r[s] <= '0;
        occ_r[s]   <= '0;
      end
    end else if (wr.we && wr.is_new) begin
      valid_r[wr.stage][wr.idx] <= 1'b1;
      occ_r[wr.stage] <= occ_r[wr.stage] + sfcc_pkg::OCC_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vq_r <= valid_r[rd_stage];
      oq_r <= occ_r[rd_stage];
    end
  end

  always_comb begin
    view = '0;
    view.occupancy = oq_r;
    for (int e = sfcc_pkg::ENTRIES - 1; e >= 0; e--) begin
      if (vq_r[e] && row_q[e * (sfcc_pkg::KEY_BITS + sfcc_pkg::COUNT_BITS)
                           + sfcc_pkg::COUNT_BITS +: sfcc_pkg::KEY_BITS] == key) begin
        view.hit = 1'b1;
        view.hit_idx = sfcc_pkg::ENTRY_BITS'(e);
        view.hit_count = row_q[e * (sfcc_pkg::KEY_BITS + sfcc_pkg::COUNT_BITS)
                               +: sfcc_pkg::COUNT_BITS];
      end
      if (!vq_r[e]) begin
        view.has_free = 1'b1;
        view.free_idx = sfcc_pkg::ENTRY_BITS'(e);
      end
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we && wr.is_new) |-> (occ_r[wr.stage] < sfcc_pkg::OCC_BITS'(sfcc_pkg::ENTRIES)))
    else $error("new entry in full stage");
  a_new_free: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we && wr.is_new) |-> !valid_r[wr.stage][wr.idx])
    else $error("new entry overwrites valid slot");
  a_upd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we && !wr.is_new) |-> valid_r[wr.stage][wr.idx])
    else $error("count update on empty slot");
`endif

endmodule

// ===== src/split_flow_counter_chain_unit.sv =====
// Flow counter chain. A packet is taken when start is high and busy low.
// The block first reads the stage 0 row in ST_READ, then searches the
// stages in ST_EVAL: it compares the key against the row just read and,
// when that stage declines, fetches the next stage's row in the same
// cycle. The result beat follows in the cycle after the decision; when no
// stage is in use, ST_READ decides the result without a table read. busy
// stays high through the result cycle, so the next packet is taken in the
// cycle after it at the earliest. Each result is shown for one cycle with
// out_valid high; the receiver cannot stall, so take it then. Tables come
// up empty after reset with no clearing pass. Write the configuration only
// while busy is low.
module split_flow_counter_chain_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_packet_length,
  output logic        out_valid,
  output logic        out_to_controller,
  output logic [1:0]  out_stage_taken,
  output logic        out_new_flow,
  output logic [15:0] out_flow_count,
  output logic [31:0] out_spill_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  sfcc_pkg::state_t state_r, state_nxt;
  logic [2:0]  stages_r;
  logic [4:0]  entries_r;
  logic [16:0] limit_r;
  logic [sfcc_pkg::KEY_BITS-1:0] key_r;
  logic [15:0] len_r;
  logic [sfcc_pkg::STAGE_BITS-1:0] stage_r, stage_nxt;
  logic [31:0] spill_r, spill_nxt;
  logic rd_en;
  sfcc_pkg::stage_view_t view;
  sfcc_pkg::wr_cmd_t wr;
  logic [2:0] nst;
  logic [4:0] cap;
  logic [16:0] lim;
  logic [16:0] sum;
  logic last_stage;
  logic res_tc_nxt, res_nf_nxt;
  logic [15:0] res_cnt_nxt;
  logic [1:0] res_st_nxt;
  logic out_valid_nxt;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != sfcc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stages_r  <= 3'd4;
      entries_r <= 5'd16;
      limit_r   <= 17'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfcc_pkg::REG_STAGES:  stages_r  <= cfg_data[2:0];
        sfcc_pkg::REG_ENTRIES: entries_r <= cfg_data[4:0];
        sfcc_pkg::REG_LIMIT:   limit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp configuration to what the hardware holds.
  assign nst = (stages_r > 3'(sfcc_pkg::STAGES)) ? 3'(sfcc_pkg::STAGES) : stages_r;
  assign cap = (entries_r > 5'(sfcc_pkg::ENTRIES)) ? 5'(sfcc_pkg::ENTRIES) : entries_r;
  assign lim = (limit_r > 17'(1 << sfcc_pkg::COUNT_BITS))
             ? 17'(1 << sfcc_pkg::COUNT_BITS) : limit_r;
  assign sum = 17'(view.hit_count) + 17'(len_r);
  assign last_stage = (3'(stage_r) + 3'd1 >= nst);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      key_r <= {in_src_addr, in_dst_addr, in_src_port, in_dst_port, in_protocol};
      len_r <= in_packet_length;
    end
  end

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    spill_nxt = spill_r;
    rd_en = 1'b0;
    wr = '0;
    out_valid_nxt = 1'b0;
    res_tc_nxt = 1'b0;
    res_st_nxt = 2'd0;
    res_nf_nxt = 1'b0;
    res_cnt_nxt = 16'd0;
    case (state_r)
      sfcc_pkg::ST_IDLE: begin
        if (start) begin
          stage_nxt = '0;
          state_nxt = sfcc_pkg::ST_READ;
        end
      end
      sfcc_pkg::ST_READ: begin
        if (nst == 3'd0) begin
          spill_nxt = spill_r + 32'd1;
          res_tc_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = sfcc_pkg::ST_DONE;
        end else begin
          rd_en = 1'b1;
          state_nxt = sfcc_pkg::ST_EVAL;
        end
      end
      sfcc_pkg::ST_EVAL: begin
        wr.stage = stage_r;
        res_st_nxt = 2'(stage_r);
        if (view.hit && sum < lim) begin
          wr.we = 1'b1;
          wr.idx = view.hit_idx;
          wr.count = sum[15:0];
          res_cnt_nxt = sum[15:0];
          out_valid_nxt = 1'b1;
          state_nxt = sfcc_pkg::ST_DONE;
        end else if (!view.hit && view.has_free && 5'(view.occupancy) < cap
                     && 17'(len_r) < lim) begin
          wr.we = 1'b1;
          wr.is_new = 1'b1;
          wr.idx = view.free_idx;
          wr.count = len_r;
          res_nf_nxt = 1'b1;
          res_cnt_nxt = len_r;
          out_valid_nxt = 1'b1;
          state_nxt = sfcc_pkg::ST_DONE;
        end else if (last_stage) begin
          spill_nxt = spill_r + 32'd1;
          res_tc_nxt = 1'b1;
          res_st_nxt = 2'd0;
          out_valid_nxt = 1'b1;
          state_nxt = sfcc_pkg::ST_DONE;
        end else begin
          // Advance to the next stage's row.
          stage_nxt = stage_r + sfcc_pkg::STAGE_BITS'(1);
          rd_en = 1'b1;
        end
      end
      sfcc_pkg::ST_DONE: state_nxt = sfcc_pkg::ST_IDLE;
      default: state_nxt = sfcc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sfcc_pkg::ST_IDLE;
      stage_r   <= '0;
      spill_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stage_r   <= stage_nxt;
      spill_r   <= spill_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_to_controller <= res_tc_nxt;
      out_stage_taken   <= res_st_nxt;
      out_new_flow      <= res_nf_nxt;
      out_flow_count    <= res_cnt_nxt;
      out_spill_total   <= spill_nxt;
    end
  end

  sfcc_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_stage (stage_nxt),
    .key      (key_r),
    .view     (view),
    .wr       (wr)
  );

`ifndef SYNTHESIS
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat held for two cycles");
  a_spill_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_to_controller) |-> (spill_r == out_spill_total))
    else $error("spill count mismatch");
  a_wr_eval: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |-> (state_r == sfcc_pkg::ST_EVAL))
    else $error("table write outside evaluation");
`endif

endmodule
